// ===== rtl/vertex_dedup_indexer_core_macros.svh =====
// Assertion macros shared by the vertex dedup indexer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef VERTEX_DEDUP_INDEXER_CORE_MACROS_SVH
`define VERTEX_DEDUP_INDEXER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define VDI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex dedup indexer: assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define VDI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex dedup indexer: assertion failed");

`endif

// ===== rtl/vdi_pkg.sv =====
// Package for the vertex dedup indexer: word widths and controller state type.
// No dependencies.
package vdi_pkg;

    localparam int WORD_W     = 32;
    localparam int WORDS      = 9;
    localparam int ENTRY_W    = WORDS * WORD_W;
    localparam int OUT_IDX_W  = 10;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } vdi_state_t;

endpackage

// ===== rtl/vertex_dedup_indexer_core.sv =====
// Vertex dedup indexer: linear search over a vertex memory, append on miss unless full.
// Depends on vdi_pkg and vertex_dedup_indexer_core_macros.svh.
//
//  channel   handshake        payload
//  -------   --------------   ------------------------------------------------
//  input     start / busy     first_of_mesh, pos_x..pos_w, tex_u, tex_v, norm_x..z
//  result    done (1 cycle)   vertex_index, is_new, overflow
//
// done is driven once the scan ends, on a match or after the last stored entry;
// the single-port vertex memory is read one entry a cycle during the scan.
// busy stays high from accept until the done word is driven.
// Reset clears the entry count and the controller; the memory needs no clearing.
// done is a one-cycle strobe; the receiver cannot stall it.
`include "vertex_dedup_indexer_core_macros.svh"

module vertex_dedup_indexer_core
    import vdi_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 first_of_mesh,
    input  logic [WORD_W-1:0]    pos_x,
    input  logic [WORD_W-1:0]    pos_y,
    input  logic [WORD_W-1:0]    pos_z,
    input  logic [WORD_W-1:0]    pos_w,
    input  logic [WORD_W-1:0]    tex_u,
    input  logic [WORD_W-1:0]    tex_v,
    input  logic [WORD_W-1:0]    norm_x,
    input  logic [WORD_W-1:0]    norm_y,
    input  logic [WORD_W-1:0]    norm_z,
    output logic                 done,
    output logic [OUT_IDX_W-1:0] vertex_index,
    output logic                 is_new,
    output logic                 overflow
);

    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    // vertex memory, one packed entry per index
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

    vdi_state_t           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [CW-1:0]        rd_addr_reg, rd_addr_next;
    logic [IW-1:0]        cmp_addr_reg, cmp_addr_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [ENTRY_W-1:0]   key_reg, key_next;
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic                 done_reg, done_next;
    logic [OUT_IDX_W-1:0] index_reg, index_next;
    logic                 is_new_reg, is_new_next;
    logic                 overflow_reg, overflow_next;

    logic                 accept;
    logic                 rd_en;
    logic                 wr_en;
    logic                 match;
    logic                 scan_end;

    assign accept   = start && (state_reg == ST_IDLE);
    assign match    = cmp_vld_reg && (rd_data_reg == key_reg);
    assign scan_end = (rd_addr_reg == count_reg);

    // controller: next state, counters and result word
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        rd_addr_next  = rd_addr_reg;
        cmp_addr_next = cmp_addr_reg;
        cmp_vld_next  = 1'b0;
        key_next      = key_reg;
        done_next     = 1'b0;
        index_next    = index_reg;
        is_new_next   = is_new_reg;
        overflow_next = overflow_reg;
        rd_en         = 1'b0;
        wr_en         = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    key_next     = {norm_z, norm_y, norm_x, tex_v, tex_u,
                                    pos_w, pos_z, pos_y, pos_x};
                    rd_addr_next = '0;
                    if (first_of_mesh)
                    begin
                        count_next = '0;
                    end
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    // hit: report the stored index
                    done_next     = 1'b1;
                    index_next    = OUT_IDX_W'(cmp_addr_reg);
                    is_new_next   = 1'b0;
                    overflow_next = 1'b0;
                    state_next    = ST_IDLE;
                end
                else if (scan_end)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    if (count_reg == DEPTH_C)
                    begin
                        // full: drop the vertex
                        index_next    = '0;
                        is_new_next   = 1'b0;
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        // miss: append at the next free index
                        wr_en         = 1'b1;
                        index_next    = OUT_IDX_W'(count_reg[IW-1:0]);
                        is_new_next   = 1'b1;
                        overflow_next = 1'b0;
                        count_next    = count_reg + 1'b1;
                    end
                end
                else
                begin
                    // advance the scan by one entry
                    rd_en         = 1'b1;
                    cmp_vld_next  = 1'b1;
                    cmp_addr_next = rd_addr_reg[IW-1:0];
                    rd_addr_next  = rd_addr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            rd_addr_reg <= '0;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rd_addr_reg <= rd_addr_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        cmp_addr_reg <= cmp_addr_next;
        index_reg    <= index_next;
        is_new_reg   <= is_new_next;
        overflow_reg <= overflow_next;
    end

    // vertex memory: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[IW-1:0]] <= key_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr_reg[IW-1:0]];
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign vertex_index = index_reg;
    assign is_new       = is_new_reg;
    assign overflow     = overflow_reg;

    // checks
    `VDI_ASSERT_NOW(a_flags_exclusive, clk, rst_n, done_reg, !(is_new_reg && overflow_reg))
    `VDI_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg == ST_SCAN)
    `VDI_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= DEPTH_C)
    `VDI_ASSERT_NOW(a_new_counted, clk, rst_n, done_reg && is_new_reg, count_reg != '0)

endmodule
